>>> rtl/bba_pkg.sv
// Shared types, codes and constants of the bitmap block allocator.
`default_nettype none
package bba_pkg;

  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 10;
  localparam int ICNT_W   = 9;
  localparam int BCNT_W   = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_IX_W = 1;
  localparam int BYTE_W   = 8;

  localparam int MAX_INODES_DEF = 256;
  localparam int MAX_BLOCKS_DEF = 1024;

  localparam logic [ICNT_W-1:0] INODE_COUNT_RST = ICNT_W'(256);
  localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = BCNT_W'(1024);

  localparam logic [CFG_IX_W-1:0] CFG_INODE_COUNT = 1'b0;
  localparam logic [CFG_IX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK_USED = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MARK_FREE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_TEST      = 2'd3;

  localparam logic POOL_INODE = 1'b0;
  localparam logic POOL_BLOCK = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ACCESS,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] result_index;
    logic             found;
    logic             bit_value;
  } rsp_t;

endpackage
`default_nettype wire

>>> rtl/bba_in_if.sv
// Request channel of the bitmap block allocator.
`default_nettype none
interface bba_in_if;
  logic                       valid;
  logic                       ready;
  logic [bba_pkg::FUNC_W-1:0] func;
  logic                       pool;
  logic [bba_pkg::IDX_W-1:0]  index;

  modport source (output valid, output func, output pool, output index, input ready);
  modport sink   (input valid, input func, input pool, input index, output ready);
endinterface
`default_nettype wire

>>> rtl/bba_out_if.sv
// Result channel of the bitmap block allocator.
`default_nettype none
interface bba_out_if;
  logic                      valid;
  logic                      ready;
  logic [bba_pkg::IDX_W-1:0] result_index;
  logic                      found;
  logic                      bit_value;

  modport source (output valid, output result_index, output found, output bit_value,
                  input ready);
  modport sink   (input valid, input result_index, input found, input bit_value,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/bba_bmap_mem.sv
// Byte-wide bitmap memory with one write port and one registered read port.
`default_nettype none
module bba_bmap_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [bba_pkg::BYTE_W-1:0] wdata,
  input  wire logic [AW-1:0]              raddr,
  output logic      [bba_pkg::BYTE_W-1:0] rdata
);

  logic [bba_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/bba_seq.sv
// Sequencer: clear pass, first-fit byte scan and single-bit read-modify-write.
`default_nettype none
module bba_seq #(
  parameter int MAX_INODES = bba_pkg::MAX_INODES_DEF,
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
  parameter int XW         = 11,
  parameter int BW         = XW - 3
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  bba_in_if.sink                          in_ch,
  input  wire logic [bba_pkg::ICNT_W-1:0] inode_count,
  input  wire logic [bba_pkg::BCNT_W-1:0] block_count,
  output logic      [BW-1:0]              rd_addr,
  output logic      [BW-1:0]              wr_addr,
  output logic      [bba_pkg::BYTE_W-1:0] wdata,
  output logic                            we_inode,
  output logic                            we_block,
  input  wire logic [bba_pkg::BYTE_W-1:0] rdata_inode,
  input  wire logic [bba_pkg::BYTE_W-1:0] rdata_block,
  output bba_pkg::rsp_t                   rsp,
  input  wire logic                       rsp_ready
);

  localparam int IDEPTH = (MAX_INODES + 7) / 8;
  localparam int BDEPTH = (MAX_BLOCKS + 7) / 8;
  localparam int MAXD   = (IDEPTH > BDEPTH) ? IDEPTH : BDEPTH;
  localparam int IDX_W  = bba_pkg::IDX_W;

  bba_pkg::state_t state_r, state_nxt;

  logic [BW-1:0]                  clr_r, clr_nxt;
  logic [bba_pkg::FUNC_W-1:0]     func_r, func_nxt;
  logic                           pool_r, pool_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic [XW-1:0]                  limit_r, limit_nxt;
  logic [BW-1:0]                  last_r, last_nxt;
  logic [BW-1:0]                  byte_r, byte_nxt;
  logic [IDX_W-1:0]               res_idx_r, res_idx_nxt;
  logic                           found_r, found_nxt;
  logic                           bit_r, bit_nxt;

  // Request decode in the idle state.
  logic [XW-1:0] cnt_x, size_x, lim_x, lim_m1, idx_x;
  logic          lim_small, idx_bad, is_alloc;

  always_comb begin
    cnt_x  = (in_ch.pool == bba_pkg::POOL_BLOCK) ? XW'(block_count) : XW'(inode_count);
    size_x = (in_ch.pool == bba_pkg::POOL_BLOCK) ? XW'(MAX_BLOCKS) : XW'(MAX_INODES);
    lim_x  = (cnt_x < size_x) ? cnt_x : size_x;
    lim_m1 = lim_x - XW'(1);
    idx_x  = XW'(in_ch.index);
    lim_small = (lim_x <= XW'(1));
    idx_bad   = (idx_x >= size_x);
    is_alloc  = (in_ch.func == bba_pkg::FUNC_ALLOC);
  end

  // Scan of one bitmap byte: entries below one and at or above the limit are skipped.
  logic [bba_pkg::BYTE_W-1:0] rd_byte;
  logic [XW-1:0]              base_x, hit_x;
  logic [7:0]                 free_v;
  logic [2:0]                 hit_p;
  logic                       hit;

  assign rd_byte = (pool_r == bba_pkg::POOL_BLOCK) ? rdata_block : rdata_inode;
  assign base_x  = {byte_r, 3'b000};

  always_comb begin
    logic [XW-1:0] e;
    for (int p = 0; p < 8; p++) begin
      e = base_x + XW'(p);
      free_v[p] = (e != '0) && (e < limit_r) && !rd_byte[7-p];
    end
    hit   = 1'b0;
    hit_p = 3'd0;
    for (int p = 7; p >= 0; p--) begin
      if (free_v[p]) begin
        hit   = 1'b1;
        hit_p = 3'(p);
      end
    end
    hit_x = base_x + XW'(hit_p);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bba_pkg::ST_CLEAR: begin
        if (clr_r == BW'(MAXD - 1)) state_nxt = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (is_alloc) state_nxt = lim_small ? bba_pkg::ST_RESP : bba_pkg::ST_SCAN;
          else          state_nxt = idx_bad ? bba_pkg::ST_RESP : bba_pkg::ST_ACCESS;
        end
      end
      bba_pkg::ST_SCAN: begin
        if (hit || byte_r == last_r) state_nxt = bba_pkg::ST_RESP;
      end
      bba_pkg::ST_ACCESS: state_nxt = bba_pkg::ST_RESP;
      bba_pkg::ST_RESP: begin
        if (rsp_ready) state_nxt = bba_pkg::ST_IDLE;
      end
      default: state_nxt = bba_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath next values.
  logic [bba_pkg::BYTE_W-1:0] acc_mask;
  logic                       acc_bit;

  assign acc_mask = bba_pkg::BYTE_W'(8'h80 >> idx_r[2:0]);
  assign acc_bit  = |(rd_byte & acc_mask);

  always_comb begin
    in_ch.ready = 1'b0;
    rd_addr     = byte_r + BW'(1);
    wr_addr     = byte_r;
    wdata       = rd_byte;
    we_inode    = 1'b0;
    we_block    = 1'b0;
    clr_nxt     = clr_r;
    func_nxt    = func_r;
    pool_nxt    = pool_r;
    idx_nxt     = idx_r;
    limit_nxt   = limit_r;
    last_nxt    = last_r;
    byte_nxt    = byte_r;
    res_idx_nxt = res_idx_r;
    found_nxt   = found_r;
    bit_nxt     = bit_r;
    case (state_r)
      bba_pkg::ST_CLEAR: begin
        wr_addr  = clr_r;
        wdata    = '0;
        we_inode = ({1'b0, clr_r} < (BW + 1)'(IDEPTH));
        we_block = ({1'b0, clr_r} < (BW + 1)'(BDEPTH));
        clr_nxt  = clr_r + BW'(1);
      end
      bba_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        rd_addr     = is_alloc ? '0 : BW'(in_ch.index[IDX_W-1:3]);
        if (in_ch.valid) begin
          func_nxt    = in_ch.func;
          pool_nxt    = in_ch.pool;
          idx_nxt     = in_ch.index;
          limit_nxt   = lim_x;
          last_nxt    = lim_m1[XW-1:3];
          byte_nxt    = '0;
          res_idx_nxt = is_alloc ? '0 : in_ch.index;
          found_nxt   = 1'b0;
          bit_nxt     = 1'b0;
        end
      end
      bba_pkg::ST_SCAN: begin
        byte_nxt = byte_r + BW'(1);
        wdata    = rd_byte | bba_pkg::BYTE_W'(8'h80 >> hit_p);
        if (hit) begin
          we_inode    = (pool_r == bba_pkg::POOL_INODE);
          we_block    = (pool_r == bba_pkg::POOL_BLOCK);
          res_idx_nxt = hit_x[IDX_W-1:0];
          found_nxt   = 1'b1;
        end
      end
      bba_pkg::ST_ACCESS: begin
        wr_addr   = BW'(idx_r[IDX_W-1:3]);
        found_nxt = 1'b1;
        bit_nxt   = acc_bit;
        if (func_r == bba_pkg::FUNC_MARK_USED) begin
          wdata    = rd_byte | acc_mask;
          we_inode = (pool_r == bba_pkg::POOL_INODE);
          we_block = (pool_r == bba_pkg::POOL_BLOCK);
        end else if (func_r == bba_pkg::FUNC_MARK_FREE) begin
          wdata    = rd_byte & ~acc_mask;
          we_inode = (pool_r == bba_pkg::POOL_INODE);
          we_block = (pool_r == bba_pkg::POOL_BLOCK);
        end
      end
      bba_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid        = (state_r == bba_pkg::ST_RESP);
  assign rsp.result_index = res_idx_r;
  assign rsp.found        = found_r;
  assign rsp.bit_value    = bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    pool_r    <= pool_nxt;
    idx_r     <= idx_nxt;
    limit_r   <= limit_nxt;
    last_r    <= last_nxt;
    byte_r    <= byte_nxt;
    res_idx_r <= res_idx_nxt;
    found_r   <= found_nxt;
    bit_r     <= bit_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/bitmap_block_allocator.sv
// Top level of the first-fit bitmap allocator for inode and data block pools.
// Mark and test pass through an access state, an allocate scans the bitmap bytes one per cycle,
// and a rejected index or empty scan range goes straight to the response state. One request
// is handled at a time; the next is taken once the result has entered the output register.
// Reset: a clearing pass zeroes both bitmaps one byte per cycle over the larger byte depth
// (128 by default) before requests are taken.
`default_nettype none
module bitmap_block_allocator #(
  parameter int MAX_INODES = bba_pkg::MAX_INODES_DEF,
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  bba_in_if.sink                            in_ch,
  bba_out_if.source                         out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [bba_pkg::CFG_IX_W-1:0] cfg_index,
  input  wire logic [bba_pkg::CFG_W-1:0]    cfg_data
);

  // Entry pointers are wide enough for the larger pool size and for the
  // 11-bit block count; byte pointers drop the three bit-select bits.
  localparam int MAXS   = (MAX_INODES > MAX_BLOCKS) ? MAX_INODES : MAX_BLOCKS;
  localparam int EW     = $clog2(MAXS + 1);
  localparam int XW     = (EW > bba_pkg::BCNT_W) ? EW : bba_pkg::BCNT_W;
  localparam int BW     = XW - 3;
  localparam int IDEPTH = (MAX_INODES + 7) / 8;
  localparam int BDEPTH = (MAX_BLOCKS + 7) / 8;
  localparam int I_AW   = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
  localparam int B_AW   = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

  // Pool size registers. They bound only the allocate scan; mark and test
  // check against the pool's physical size.
  logic [bba_pkg::ICNT_W-1:0] inode_count_r;
  logic [bba_pkg::BCNT_W-1:0] block_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inode_count_r <= bba_pkg::INODE_COUNT_RST;
      block_count_r <= bba_pkg::BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bba_pkg::CFG_INODE_COUNT: inode_count_r <= cfg_data[bba_pkg::ICNT_W-1:0];
        bba_pkg::CFG_BLOCK_COUNT: block_count_r <= cfg_data[bba_pkg::BCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Memory access signals driven by the sequencer. Both bitmaps share the
  // addresses and write data; the write enables pick the pool.
  logic [BW-1:0]                  rd_addr, wr_addr;
  logic [bba_pkg::BYTE_W-1:0]     wdata, rdata_inode, rdata_block;
  logic                           we_inode, we_block;
  bba_pkg::rsp_t                  rsp;
  logic                           rsp_ready;

  bba_seq #(
    .MAX_INODES (MAX_INODES),
    .MAX_BLOCKS (MAX_BLOCKS),
    .XW         (XW),
    .BW         (BW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .inode_count (inode_count_r),
    .block_count (block_count_r),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .wdata       (wdata),
    .we_inode    (we_inode),
    .we_block    (we_block),
    .rdata_inode (rdata_inode),
    .rdata_block (rdata_block),
    .rsp         (rsp),
    .rsp_ready   (rsp_ready)
  );

  bba_bmap_mem #(
    .DEPTH (IDEPTH),
    .AW    (I_AW)
  ) u_inode_map (
    .clk   (clk),
    .we    (we_inode),
    .waddr (I_AW'(wr_addr)),
    .wdata (wdata),
    .raddr (I_AW'(rd_addr)),
    .rdata (rdata_inode)
  );

  bba_bmap_mem #(
    .DEPTH (BDEPTH),
    .AW    (B_AW)
  ) u_block_map (
    .clk   (clk),
    .we    (we_block),
    .waddr (B_AW'(wr_addr)),
    .wdata (wdata),
    .raddr (B_AW'(rd_addr)),
    .rdata (rdata_block)
  );

  // Output register. It frees the sequencer as soon as a result is handed
  // over, so a new request can start while the result transaction waits.
  logic                      out_valid_r;
  logic [bba_pkg::IDX_W-1:0] out_index_r;
  logic                      out_found_r;
  logic                      out_bit_r;

  assign rsp_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_r <= rsp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.valid && rsp_ready) begin
      out_index_r <= rsp.result_index;
      out_found_r <= rsp.found;
      out_bit_r   <= rsp.bit_value;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_index = out_index_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.bit_value    = out_bit_r;

endmodule
`default_nettype wire

>>> test/bitmap_block_allocator_test.sv
// Self-checking testbench of the bitmap block allocator: directed and random requests.
module bitmap_block_allocator_test;
  import bba_pkg::*;

  // Pool sizes of the default build and the stimulus shape.
  localparam int INODE_SLOTS  = MAX_INODES_DEF;
  localparam int BLOCK_SLOTS  = MAX_BLOCKS_DEF;
  localparam int MAX_WAIT     = 12;
  localparam int HOLD_OFF     = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 10;
  // The slowest correct run, with full data pool scans plus the idling on both
  // sides, stays well inside this limit, which leaves plenty of room, the
  // clearing pass after reset included.
  localparam int CYCLE_LIMIT  = 600_000;

  // What one result transaction is expected to carry.
  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic             found;
    logic             bit_value;
  } grant_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_IX_W-1:0] cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  bba_in_if  in_ch ();
  bba_out_if out_ch ();

  bitmap_block_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our own picture of both bitmaps, one flag per entry. Row POOL_INODE only
  // uses its first INODE_SLOTS entries. The bit order inside the bitmap bytes
  // is not visible at the ports, so it is not modeled here.
  bit                slot_used [2][BLOCK_SLOTS];
  logic [ICNT_W-1:0] inode_limit = INODE_COUNT_RST;
  logic [BCNT_W-1:0] block_limit = BLOCK_COUNT_RST;

  grant_t pending_grants [$];
  int     mismatch_count = 0;
  int     cycle_count    = 0;
  // When set, neither side idles between transactions.
  bit     no_gaps        = 1'b0;
  // A request for one long stall of the result channel; the receiver takes it
  // over and counts it down itself.
  int     hold_off_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the bitmap picture and returns what the block
  // should answer. Allocate scans from entry 1 up to the smaller of the
  // programmed count and the pool size; entry 0 is never handed out. Mark and
  // test ignore the counts and only check the pool size.
  function automatic grant_t apply_request(input logic [FUNC_W-1:0] func, input logic pool,
                                           input logic [IDX_W-1:0] slot);
    grant_t g;
    int     size;
    int     limit;
    g     = '0;
    size  = (pool == POOL_BLOCK) ? BLOCK_SLOTS : INODE_SLOTS;
    limit = (pool == POOL_BLOCK) ? int'(block_limit) : int'(inode_limit);
    if (limit > size) limit = size;
    if (func == FUNC_ALLOC) begin
      // A full pool, or a count of 0 or 1, leaves the result all zero.
      for (int i = 1; i < limit; i++) begin
        if (!slot_used[pool][i]) begin
          slot_used[pool][i] = 1'b1;
          g.result_index     = IDX_W'(i);
          g.found            = 1'b1;
          break;
        end
      end
    end else begin
      g.result_index = slot;
      // An index past the pool size is echoed with found and bit_value low.
      if (int'(slot) < size) begin
        g.found     = 1'b1;
        g.bit_value = slot_used[pool][slot];
        if (func == FUNC_MARK_USED) slot_used[pool][slot] = 1'b1;
        else if (func == FUNC_MARK_FREE) slot_used[pool][slot] = 1'b0;
      end
    end
    return g;
  endfunction

  // Offers one request after a random gap and waits for its transaction. The
  // valid line stays high into the next request when that one draws no gap.
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic pool,
                              input logic [IDX_W-1:0] slot);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= func;
    in_ch.pool  <= pool;
    in_ch.index <= slot;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_grants.push_back(apply_request(func, pool, slot));
  endtask

  // Stops offering requests and waits until every expected result is in.
  // Every request yields a result, so the block is idle from then on.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_grants.size() != 0);
  endtask

  // Presents one register write for a single edge; the caller drops the
  // write enable once its last write is done.
  task automatic write_count(input logic [CFG_IX_W-1:0] which, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
    if (which == CFG_INODE_COUNT) inode_limit = ICNT_W'(value);
    else block_limit = BCNT_W'(value);
  endtask

  // Both count registers are reprogrammed only once the block is idle.
  task automatic set_counts(input int inodes, input int blocks);
    wait_idle();
    write_count(CFG_INODE_COUNT, inodes);
    write_count(CFG_BLOCK_COUNT, blocks);
    cfg_we <= 1'b0;
  endtask

  // Random requests: alloc_pct percent allocations, the rest spread over the
  // three single-entry operations; inode_pct percent go to the inode pool.
  // Most indexes stay low so that marks and frees land where allocation works;
  // one in eight spans the whole index field.
  task automatic run_random(input int items, input int alloc_pct, input int inode_pct,
                            input int index_max);
    logic [FUNC_W-1:0] func;
    logic              pool;
    logic [IDX_W-1:0]  slot;
    repeat (items) begin
      if ($urandom_range(1, 100) <= alloc_pct) begin
        func = FUNC_ALLOC;
      end else begin
        case ($urandom_range(0, 2))
          0: func = FUNC_MARK_USED;
          1: func = FUNC_MARK_FREE;
          default: func = FUNC_TEST;
        endcase
      end
      pool = ($urandom_range(1, 100) <= inode_pct) ? POOL_INODE : POOL_BLOCK;
      if ($urandom_range(0, 7) == 0) slot = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      else slot = IDX_W'($urandom_range(0, index_max));
      send_request(func, pool, slot);
    end
  endtask

  // Right after reset every entry is free, at both ends of the inode pool and at the top of the block pool.
  task automatic test_reset_state();
    send_request(FUNC_TEST, POOL_INODE, '0);
    send_request(FUNC_TEST, POOL_INODE, IDX_W'(INODE_SLOTS - 1));
    send_request(FUNC_TEST, POOL_BLOCK, IDX_W'(BLOCK_SLOTS - 1));
  endtask

  // Indexes past the inode pool size are rejected and change nothing.
  task automatic test_out_of_range();
    send_request(FUNC_TEST, POOL_INODE, IDX_W'(INODE_SLOTS));
    send_request(FUNC_MARK_USED, POOL_INODE, '1);
    send_request(FUNC_MARK_FREE, POOL_INODE, IDX_W'(2 * INODE_SLOTS));
  endtask

  // Marks report the previous bit state, including marking twice in a row.
  task automatic test_mark_ops();
    send_request(FUNC_MARK_USED, POOL_BLOCK, '1);
    send_request(FUNC_TEST, POOL_BLOCK, '1);
    send_request(FUNC_MARK_USED, POOL_BLOCK, '1);
    send_request(FUNC_MARK_FREE, POOL_BLOCK, '1);
    send_request(FUNC_MARK_FREE, POOL_BLOCK, '1);
    send_request(FUNC_MARK_USED, POOL_INODE, '0);
    send_request(FUNC_TEST, POOL_INODE, '0);
  endtask

  // Allocation takes the lowest free entry from 1 up and reuses freed ones.
  task automatic test_first_fit();
    send_request(FUNC_ALLOC, POOL_INODE, '0);
    send_request(FUNC_ALLOC, POOL_INODE, '0);
    send_request(FUNC_MARK_FREE, POOL_INODE, IDX_W'(1));
    send_request(FUNC_ALLOC, POOL_INODE, '0);
    send_request(FUNC_ALLOC, POOL_BLOCK, '0);
    send_request(FUNC_MARK_USED, POOL_BLOCK, IDX_W'(2));
    send_request(FUNC_ALLOC, POOL_BLOCK, '0);
  endtask

  // A full pool, counts of 0 and 1 that leave nothing to scan, and counts
  // above the pool size, which the scan clips to the size.
  task automatic test_pool_full();
    set_counts(3, 0);
    send_request(FUNC_ALLOC, POOL_INODE, '0);
    send_request(FUNC_ALLOC, POOL_BLOCK, '0);
    set_counts(1, 1);
    send_request(FUNC_ALLOC, POOL_INODE, '0);
    send_request(FUNC_ALLOC, POOL_BLOCK, '0);
    set_counts((1 << ICNT_W) - 1, (1 << BCNT_W) - 1);
    send_request(FUNC_ALLOC, POOL_INODE, '0);
    send_request(FUNC_ALLOC, POOL_BLOCK, '0);
  endtask

  // Mixed traffic under the reset counts, small counts that fill up quickly,
  // and the degenerate counts the other way round.
  task automatic test_random_mix();
    set_counts(INODE_SLOTS, BLOCK_SLOTS);
    run_random(40, 35, 50, 63);
    set_counts($urandom_range(2, 20), $urandom_range(2, 40));
    run_random(60, 40, 50, 47);
    set_counts(0, 1);
    run_random(20, 40, 50, 15);
  endtask

  // Mostly inode allocations under the largest count, so that the inode pool
  // runs full and the scan stops at the pool size.
  task automatic test_fill_inode_pool();
    set_counts((1 << ICNT_W) - 1, (1 << BCNT_W) - 1);
    run_random(300, 95, 95, (1 << IDX_W) - 1);
  endtask

  // The receiver stalls for a long stretch while requests keep coming, so the
  // block holds its result and stops taking requests.
  task automatic test_backpressure();
    no_gaps         = 1'b1;
    hold_off_cycles = HOLD_OFF;
    run_random(12, 30, 50, 63);
    no_gaps = 1'b0;
  endtask

  // Back-to-back transactions on both channels.
  task automatic test_back_to_back();
    no_gaps = 1'b1;
    run_random(30, 35, 50, 31);
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.func  <= FUNC_ALLOC;
    in_ch.pool  <= POOL_INODE;
    in_ch.index <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // The first requests simply wait out the clearing pass after reset.
    test_reset_state();
    test_out_of_range();
    test_mark_ops();
    test_first_fit();
    test_pool_full();
    test_random_mix();
    test_fill_inode_pool();
    test_backpressure();
    test_back_to_back();

    // Let any stray result show up before the verdict.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: a random stall before each transaction, or the long hold-off
  // when one has been requested.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // Every result transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_grants.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("Result with no request pending: index %0d found %0b bit %0b",
                   out_ch.result_index, out_ch.found, out_ch.bit_value);
      end else begin
        want = pending_grants.pop_front();
        if (out_ch.result_index !== want.result_index || out_ch.found !== want.found ||
            out_ch.bit_value !== want.bit_value) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display({"Mismatch: expected index %0d found %0b bit %0b, ",
                      "got index %0d found %0b bit %0b"},
                     want.result_index, want.found, want.bit_value,
                     out_ch.result_index, out_ch.found, out_ch.bit_value);
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
